// ----- design/dqfa_pkg.sv -----
package dqfa_pkg;

  // Buffer size in bytes; positions and offsets are sized to hold it plus
  // one label length beyond it.
  localparam int unsigned MaxPacket = 512;
  localparam int unsigned PosW      = $clog2(MaxPacket + 257);
  localparam int unsigned HdrLen    = 12;
  localparam int unsigned RecLen    = 16;

  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 32;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgAnswerAddress = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgAnswerTtl     = 1'd1;

  localparam logic [31:0] AddrReset = 32'd0;
  localparam logic [7:0]  TtlReset  = 8'd60;

  // Header and record byte values
  localparam logic [7:0] FlagsHi    = 8'h81;
  localparam logic [7:0] FlagsLo    = 8'h80;
  localparam logic [7:0] CountOne   = 8'h01;
  localparam logic [7:0] ByteZero   = 8'h00;
  localparam logic [7:0] PtrMark    = 8'hC0;
  localparam logic [7:0] PtrOffset  = 8'h0C;
  localparam logic [7:0] RdLength   = 8'h04;
  localparam logic [1:0] PtrTag     = 2'b11;

  typedef enum logic [1:0] {
    PhName = 2'd0,
    PhPtr  = 2'd1,
    PhDone = 2'd2
  } phase_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       discard;
  } out_item_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [7:0]  ttl;
  } cfg_t;

  // One parsed input byte on its way to the output sequencer
  typedef struct packed {
    logic       emit;
    logic [7:0] data;
    logic       last;
    logic       bad;
  } job_t;

  // Response header bytes 2..11
  function automatic logic [7:0] hdr_byte(input logic [3:0] pos);
    logic [7:0] b;
    b = ByteZero;
    if (pos == 4'd2) begin
      b = FlagsHi;
    end else if (pos == 4'd3) begin
      b = FlagsLo;
    end else if (pos == 4'd5 || pos == 4'd7) begin
      b = CountOne;
    end
    return b;
  endfunction

  // Appended A record: name pointer, type A, class IN, TTL, length, address
  function automatic logic [7:0] rec_byte(input logic [3:0] idx, input cfg_t cfg);
    logic [7:0] b;
    b = ByteZero;
    unique case (idx)
      4'd0:  b = PtrMark;
      4'd1:  b = PtrOffset;
      4'd2:  b = ByteZero;
      4'd3:  b = CountOne;
      4'd4:  b = ByteZero;
      4'd5:  b = CountOne;
      4'd6:  b = ByteZero;
      4'd7:  b = ByteZero;
      4'd8:  b = ByteZero;
      4'd9:  b = cfg.ttl;
      4'd10: b = ByteZero;
      4'd11: b = RdLength;
      4'd12: b = cfg.addr[31:24];
      4'd13: b = cfg.addr[23:16];
      4'd14: b = cfg.addr[15:8];
      4'd15: b = cfg.addr[7:0];
    endcase
    return b;
  endfunction

endpackage

// ----- design/dqfa_cfg.sv -----
module dqfa_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dqfa_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dqfa_pkg::CfgDataW-1:0] cfg_data_i,
  output dqfa_pkg::cfg_t                cfg_o
);

  dqfa_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        dqfa_pkg::CfgAnswerAddress: cfg_d.addr = cfg_data_i;
        dqfa_pkg::CfgAnswerTtl:     cfg_d.ttl  = cfg_data_i[7:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.addr <= dqfa_pkg::AddrReset;
      cfg_q.ttl  <= dqfa_pkg::TtlReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- design/dqfa_parse.sv -----
module dqfa_parse (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               take_i,
  input  dqfa_pkg::in_item_t item_i,
  output dqfa_pkg::job_t     job_o
);

  localparam int unsigned PosW = dqfa_pkg::PosW;

  logic [PosW-1:0]  pos_q, pos_d;
  logic [PosW-1:0]  nla_q, nla_d;
  logic [PosW-1:0]  qend_q, qend_d;
  dqfa_pkg::phase_e phase_q, phase_d;

  logic             in_range;
  logic [7:0]       b;

  assign b        = item_i.in_byte;
  assign in_range = pos_q < PosW'(dqfa_pkg::MaxPacket);

  always_comb begin
    pos_d       = pos_q;
    nla_d       = nla_q;
    qend_d      = qend_q;
    phase_d     = phase_q;
    job_o.emit  = 1'b0;
    job_o.data  = b;
    job_o.last  = item_i.in_last;

    if (in_range) begin
      job_o.emit = 1'b1;
      pos_d      = pos_q + PosW'(1);
      if (pos_q >= PosW'(2) && pos_q < PosW'(dqfa_pkg::HdrLen)) begin
        job_o.data = dqfa_pkg::hdr_byte(pos_q[3:0]);
      end else if (pos_q >= PosW'(dqfa_pkg::HdrLen)) begin
        unique case (phase_q)
          dqfa_pkg::PhName: begin
            if (pos_q == nla_q) begin
              if (b == dqfa_pkg::ByteZero) begin
                qend_d  = pos_q + PosW'(5);
                phase_d = dqfa_pkg::PhDone;
              end else if (b[7:6] == dqfa_pkg::PtrTag) begin
                qend_d  = pos_q + PosW'(6);
                phase_d = dqfa_pkg::PhPtr;
              end else begin
                nla_d = pos_q + PosW'(b) + PosW'(1);
              end
            end
          end
          dqfa_pkg::PhPtr: phase_d = dqfa_pkg::PhDone;
          dqfa_pkg::PhDone: begin
            if (pos_q >= qend_q) begin
              job_o.emit = 1'b0;
            end
          end
          default: phase_d = phase_q;
        endcase
      end
    end

    job_o.bad = (pos_d < PosW'(dqfa_pkg::HdrLen)) || (phase_d != dqfa_pkg::PhDone) ||
                (qend_d > pos_d) ||
                (qend_d > PosW'(dqfa_pkg::MaxPacket - dqfa_pkg::RecLen));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      nla_q   <= PosW'(dqfa_pkg::HdrLen);
      qend_q  <= '0;
      phase_q <= dqfa_pkg::PhName;
    end else if (take_i) begin
      if (item_i.in_last) begin
        pos_q   <= '0;
        nla_q   <= PosW'(dqfa_pkg::HdrLen);
        qend_q  <= '0;
        phase_q <= dqfa_pkg::PhName;
      end else begin
        pos_q   <= pos_d;
        nla_q   <= nla_d;
        qend_q  <= qend_d;
        phase_q <= phase_d;
      end
    end
  end

endmodule

// ----- design/dqfa_emit.sv -----
module dqfa_emit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dqfa_pkg::cfg_t      cfg_i,
  input  logic                job_valid_i,
  input  dqfa_pkg::job_t      job_i,
  output logic                job_ready_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dqfa_pkg::out_item_t out_o
);

  logic                job_full_q;
  dqfa_pkg::job_t      job_q;
  logic                data_done_q;
  logic [3:0]          rec_idx_q;
  logic                out_valid_q;
  dqfa_pkg::out_item_t out_q;

  dqfa_pkg::out_item_t cur;
  logic                cur_data;
  logic                cur_rec;
  logic                cur_final;
  logic                out_load;
  logic                job_done;
  logic                job_take;

  // Pick the next result of the held job: forwarded byte, drop marker or record byte
  always_comb begin
    cur       = '0;
    cur_data  = 1'b0;
    cur_rec   = 1'b0;
    cur_final = 1'b0;
    priority if (!data_done_q && job_q.emit && !(job_q.last && job_q.bad)) begin
      cur.out_byte = job_q.data;
      cur_data     = 1'b1;
      cur_final    = !job_q.last;
    end else if (job_q.last && job_q.bad) begin
      cur.out_last = 1'b1;
      cur.discard  = 1'b1;
      cur_final    = 1'b1;
    end else begin
      cur.out_byte = dqfa_pkg::rec_byte(rec_idx_q, cfg_i);
      cur.out_last = (rec_idx_q == 4'd15);
      cur_rec      = 1'b1;
      cur_final    = cur.out_last;
    end
  end

  assign out_load    = job_full_q && (!out_valid_q || !out_stall_i);
  assign job_done    = out_load && cur_final;
  assign job_ready_o = !job_full_q || job_done;
  assign job_take    = job_valid_i && job_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_full_q  <= 1'b0;
      data_done_q <= 1'b0;
      rec_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (job_take) begin
        job_full_q  <= 1'b1;
        data_done_q <= 1'b0;
        rec_idx_q   <= '0;
      end else begin
        if (job_done) begin
          job_full_q <= 1'b0;
        end
        if (out_load && cur_data) begin
          data_done_q <= 1'b1;
        end
        if (out_load && cur_rec) begin
          rec_idx_q <= rec_idx_q + 4'd1;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_take) begin
      job_q <= job_i;
    end
    if (out_load) begin
      out_q <= cur;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ----- design/dns_query_to_fixed_answer_core.sv -----
// Path: a byte passes through the job register and then the output register before its response transfer is offered.
// Throughput: one byte per cycle while the output does not stall; a good datagram's last byte yields
//   up to 17 results, so the input stalls while the A record is appended.
// Reset (rst_ni low, asynchronous): parser restarts at offset 0, job and output
//   registers empty, answer address 0 and answer TTL 60.
module dns_query_to_fixed_answer_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // query byte stream
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  dqfa_pkg::in_item_t            in_i,
  // response byte stream
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output dqfa_pkg::out_item_t           out_o,
  // register writes
  input  logic                          cfg_we_i,
  input  logic [dqfa_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dqfa_pkg::CfgDataW-1:0] cfg_data_i
);

  dqfa_pkg::cfg_t cfg;
  dqfa_pkg::job_t job;
  logic           job_ready;
  logic           in_take;
  logic           job_valid;

  // Hold the input whenever the job register cannot take a new byte this cycle.
  assign in_stall_o = !job_ready;
  assign in_take    = in_valid_i && job_ready;

  // Bytes past the question only advance the parser, bytes past the buffer leave
  // it as it is; drop them unless they close the datagram.
  assign job_valid  = in_take && (job.emit || job.last);

  dqfa_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Header rewrite and QNAME walk, one byte per transfer
  dqfa_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (in_take),
    .item_i (in_i),
    .job_o  (job)
  );

  // Job register, record append sequencer and output register
  dqfa_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_ready_o (job_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule

// ----- design/dqfa_checker.sv -----
module dqfa_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input dqfa_pkg::out_item_t out_o
);

  // A drop marker is always the closing, zeroed result of its datagram.
  a_discard_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.discard |-> out_o.out_last && out_o.out_byte == 8'h00)
    else $error("discard without out_last or with nonzero byte");

  // Nothing is offered once reset has been held across a clock edge.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni && $past(!rst_ni) |-> !out_valid_o)
    else $error("output valid during reset");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_o))
    else $error("output payload changed while stalled");

endmodule

bind dns_query_to_fixed_answer_core dqfa_checker u_dqfa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_o       (out_o)
);
